@@ rtl/core/sha1bs_pkg.sv @@
// Package for the SHA-1 byte stream hasher: request and status codes,
// sequencer states, queue item type and SHA-1 constants.
// No dependencies.
package sha1bs_pkg;

  typedef enum logic [1:0] {
    REQ_APPEND  = 2'd0,
    REQ_FINISH  = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_AFTER_FIN = 2'd1,
    STAT_CORRUPT  = 2'd2,
    STAT_RSVD     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FOLD,
    ST_FINAL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } item_t;

  localparam int unsigned QueueDepth = 2;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hefcdab89;
  localparam logic [31:0] H2 = 32'h98badcfe;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hc3d2e1f0;

endpackage

@@ rtl/core/sha1bs_front.sv @@
// Front end of the SHA-1 byte stream hasher: accepts request transactions
// into a two-entry queue that the back end drains. Uses sha1bs_pkg.
module sha1bs_front import sha1bs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] data_byte_i,
  output logic       q_valid_o,
  output item_t      q_item_o,
  input  logic       q_pop_i
);

  item_t      mem_q [QueueDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_stall_o = (cnt_q == 2'(QueueDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];

  // Store accepted transactions
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{req_type: req_type_i, data_byte: data_byte_i};
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      case ({push, q_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/core/sha1bs_core.sv @@
// Back end of the SHA-1 byte stream hasher: block buffer, padding sequencer,
// one-round-per-cycle compression and digest output register. Uses sha1bs_pkg.
module sha1bs_core import sha1bs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic [1:0]  status_o,
  output logic        last_result_o
);

  state_e        state_q, state_d, after_q, after_d;
  logic [511:0]  buf_q;
  logic [6:0]    fill_q, fill_d;
  logic [63:0]   bit_q, bit_d, bit_inc;
  logic          fin_q, fin_d, cor_q, cor_d;
  logic          pad_first_q, pad_first_d, len_ok_q, len_ok_d, len_ok_eff;
  logic [6:0]    rnd_q;
  logic [31:0]   a_q, b_q, c_q, d_q, e_q;
  logic [31:0]   h_q [5];
  logic [2:0]    emit_idx_q, emit_idx_d;
  status_e       emit_st_q, emit_st_d;
  logic          out_valid_q, out_valid_d, out_load;
  logic          shift_en, restart, start_comp;
  logic [7:0]    shift_byte, len_byte;
  logic [31:0]   w_sel, w_new, f_val, k_val, t_val;
  logic [31:0]   dw_q;
  logic [2:0]    wi_q;
  status_e       st_q;
  logic          last_q;

  assign bit_inc  = bit_q + 64'd8;
  assign out_load = !out_valid_q || !out_stall_i;
  assign len_ok_eff = pad_first_q ? (fill_q <= 7'd55) : len_ok_q;
  assign len_byte = 8'(bit_q >> {3'd7 - fill_q[2:0], 3'b000});

  // Next state and control
  always_comb begin
    state_d     = state_q;
    after_d     = after_q;
    fill_d      = fill_q;
    bit_d       = bit_q;
    fin_d       = fin_q;
    cor_d       = cor_q;
    pad_first_d = pad_first_q;
    len_ok_d    = len_ok_q;
    emit_idx_d  = emit_idx_q;
    emit_st_d   = emit_st_q;
    shift_en    = 1'b0;
    shift_byte  = 8'h00;
    restart     = 1'b0;
    start_comp  = 1'b0;
    q_pop_o     = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_item_i.req_type)
            REQ_APPEND: begin
              if (fin_q) begin
                cor_d      = 1'b1;
                emit_st_d  = STAT_AFTER_FIN;
                emit_idx_d = 3'd0;
                state_d    = ST_EMIT;
              end else if (cor_q) begin
                emit_st_d  = STAT_CORRUPT;
                emit_idx_d = 3'd0;
                state_d    = ST_EMIT;
              end else begin
                shift_en   = 1'b1;
                shift_byte = q_item_i.data_byte;
                fill_d     = fill_q + 7'd1;
                bit_d      = bit_inc;
                if (bit_inc == 64'd0) cor_d = 1'b1;
                if (fill_q == 7'd63) begin
                  start_comp = 1'b1;
                  after_d    = ST_IDLE;
                  state_d    = ST_COMP;
                end
              end
            end
            REQ_FINISH: begin
              emit_idx_d = 3'd0;
              if (cor_q) begin
                emit_st_d = STAT_CORRUPT;
                state_d   = ST_EMIT;
              end else if (!fin_q) begin
                pad_first_d = 1'b1;
                state_d     = ST_PAD;
              end else begin
                emit_st_d = STAT_OK;
                state_d   = ST_EMIT;
              end
            end
            REQ_RESTART: begin
              restart = 1'b1;
              fill_d  = 7'd0;
              bit_d   = 64'd0;
              fin_d   = 1'b0;
              cor_d   = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_PAD: begin
        shift_en    = 1'b1;
        shift_byte  = pad_first_q ? 8'h80 :
                      ((len_ok_q && fill_q >= 7'd56) ? len_byte : 8'h00);
        fill_d      = fill_q + 7'd1;
        pad_first_d = 1'b0;
        len_ok_d    = len_ok_eff;
        if (fill_q == 7'd63) begin
          start_comp = 1'b1;
          state_d    = ST_COMP;
          after_d    = len_ok_eff ? ST_FINAL : ST_PAD;
          len_ok_d   = 1'b1;
        end
      end
      ST_COMP: begin
        if (rnd_q == 7'd79) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        fill_d  = 7'd0;
        state_d = after_q;
      end
      ST_FINAL: begin
        fin_d      = 1'b1;
        bit_d      = 64'd0;
        fill_d     = 7'd0;
        emit_st_d  = STAT_OK;
        emit_idx_d = 3'd0;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (emit_st_q != STAT_OK || emit_idx_q == 3'd4) begin
            state_d = ST_IDLE;
          end else begin
            emit_idx_d = emit_idx_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      after_q     <= ST_IDLE;
      fill_q      <= 7'd0;
      bit_q       <= 64'd0;
      fin_q       <= 1'b0;
      cor_q       <= 1'b0;
      pad_first_q <= 1'b0;
      len_ok_q    <= 1'b0;
      emit_idx_q  <= 3'd0;
      emit_st_q   <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      after_q     <= after_d;
      fill_q      <= fill_d;
      bit_q       <= bit_d;
      fin_q       <= fin_d;
      cor_q       <= cor_d;
      pad_first_q <= pad_first_d;
      len_ok_q    <= len_ok_d;
      emit_idx_q  <= emit_idx_d;
      emit_st_q   <= emit_st_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Round function: oldest schedule word sits in the top 32 bits
  assign w_sel = (rnd_q < 7'd16) ? buf_q[511:480] : w_new;
  assign w_new = {buf_q[511-32*13 -: 32] ^ buf_q[511-32*8 -: 32] ^
                  buf_q[511-32*2 -: 32] ^ buf_q[511:480]} << 1 |
                 {31'd0, buf_q[511-32*13] ^ buf_q[511-32*8] ^
                  buf_q[511-32*2] ^ buf_q[511]};

  always_comb begin
    if (rnd_q < 7'd20) begin
      f_val = (b_q & c_q) | (~b_q & d_q);
      k_val = K0;
    end else if (rnd_q < 7'd40) begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K1;
    end else if (rnd_q < 7'd60) begin
      f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_val = K2;
    end else begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K3;
    end
  end

  assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + w_sel + k_val;

  // Shift buffer, run rounds
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      buf_q <= {buf_q[503:0], shift_byte};
    end else if (state_q == ST_COMP) begin
      buf_q <= {buf_q[479:0], w_sel};
    end
    if (start_comp) begin
      rnd_q <= 7'd0;
      a_q   <= h_q[0];
      b_q   <= h_q[1];
      c_q   <= h_q[2];
      d_q   <= h_q[3];
      e_q   <= h_q[4];
    end else if (state_q == ST_COMP) begin
      rnd_q <= rnd_q + 7'd1;
      a_q   <= t_val;
      b_q   <= a_q;
      c_q   <= {b_q[1:0], b_q[31:2]};
      d_q   <= c_q;
      e_q   <= d_q;
    end
  end

  // Chain value: reload on restart, fold after the last round
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q[0] <= H0;
      h_q[1] <= H1;
      h_q[2] <= H2;
      h_q[3] <= H3;
      h_q[4] <= H4;
    end else if (restart) begin
      h_q[0] <= H0;
      h_q[1] <= H1;
      h_q[2] <= H2;
      h_q[3] <= H3;
      h_q[4] <= H4;
    end else if (state_q == ST_FOLD) begin
      h_q[0] <= h_q[0] + a_q;
      h_q[1] <= h_q[1] + b_q;
      h_q[2] <= h_q[2] + c_q;
      h_q[3] <= h_q[3] + d_q;
      h_q[4] <= h_q[4] + e_q;
    end
  end

  // Load output register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && out_load) begin
      dw_q   <= (emit_st_q == STAT_OK) ? h_q[emit_idx_q] : 32'd0;
      wi_q   <= (emit_st_q == STAT_OK) ? emit_idx_q : 3'd0;
      st_q   <= emit_st_q;
      last_q <= (emit_st_q != STAT_OK) || (emit_idx_q == 3'd4);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = dw_q;
  assign word_index_o  = wi_q;
  assign status_o      = st_q;
  assign last_result_o = last_q;

endmodule

@@ rtl/core/sha1_byte_stream_hasher.sv @@
// SHA-1 byte stream hasher, top level.
// Request channel: in_valid_i/in_stall_o with req_type_i (0 append byte,
//   1 finish and read digest, 2 restart) and data_byte_i.
// Result channel: out_valid_o/out_stall_i with digest_word_o, word_index_o,
//   status_o and last_result_o; a transaction moves when valid is high and
//   stall is low.
// A two-entry queue takes requests while the back end works.
// An append shifts its byte into the block buffer; every 64th byte also runs
//   the compression, 80 rounds at one round per cycle followed by a fold
//   of the round results into the chain value.
// A first finish feeds the padding bytes one per cycle through the block
//   buffer and runs one or two compressions, then emits five digest words,
//   one per cycle unless the receiver stalls; later finishes emit them again.
// Error results (byte after finish, corrupted context) are single words
//   with status set and last_result high.
// Reset loads the SHA-1 initial hash and clears counts and flags; the block
//   takes requests from the first cycle after reset.
// While the receiver stalls, the current result holds and the back end
//   waits before its next result; the queue keeps taking requests until full.
// Uses sha1bs_pkg, sha1bs_front and sha1bs_core.
module sha1_byte_stream_hasher import sha1bs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic [1:0]  status_o,
  output logic        last_result_o
);

  logic  q_valid, q_pop;
  item_t q_item;

  sha1bs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .data_byte_i (data_byte_i),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  sha1bs_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .status_o      (status_o),
    .last_result_o (last_result_o)
  );

endmodule

@@ rtl/core/sha1bs_checker.sv @@
// Port checker for the SHA-1 byte stream hasher, bound to the top level.
// Uses sha1bs_pkg status codes.
module sha1bs_checker import sha1bs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic [1:0]  status_o,
  input logic        last_result_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digest_word_o)
      && $stable(word_index_o) && $stable(last_result_o))
    else $error("stalled result changed");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_OK |->
      digest_word_o == 32'd0 && word_index_o == 3'd0 && last_result_o)
    else $error("error result malformed");

  a_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_OK |-> last_result_o == (word_index_o == 3'd4))
    else $error("last flag does not match word index");

  a_next_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && status_o == STAT_OK && !last_result_o
      ##1 out_valid_o |-> status_o == STAT_OK && word_index_o == $past(word_index_o) + 3'd1)
    else $error("digest words out of order");

endmodule

bind sha1_byte_stream_hasher sha1bs_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .digest_word_o (digest_word_o),
  .word_index_o  (word_index_o),
  .status_o      (status_o),
  .last_result_o (last_result_o)
);
